// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the policer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock outside reset.
`define MCLBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define MCLBP_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/mclbp_pkg.sv -----
// Types, constants and helpers of the multi-class leaky-bucket policer.
`default_nettype none
package mclbp_pkg;

  localparam int BUCKETS_DEF = 1024;
  localparam int IDX_W       = 10;
  localparam int TIME_W      = 48;
  localparam int LEVEL_W     = 32;
  localparam int LIMIT_W     = 40;
  localparam int RATE_W      = 24;
  localparam int BURST_W     = 16;
  localparam int NUM_CLASSES = 5;
  localparam int CLS_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int FAIL_W      = 3;
  localparam int RECIP_SHIFT = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TO           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TO_IP        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TO_IP_FROM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_TO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_TO_IP = 3'd4;

  // failure codes
  localparam logic [FAIL_W-1:0] FAIL_NONE         = 3'd0;
  localparam logic [FAIL_W-1:0] FAIL_BOUNCE_TO    = 3'd1;
  localparam logic [FAIL_W-1:0] FAIL_BOUNCE_TO_IP = 3'd2;
  localparam logic [FAIL_W-1:0] FAIL_TO_IP_FROM   = 3'd3;
  localparam logic [FAIL_W-1:0] FAIL_TO_IP        = 3'd4;
  localparam logic [FAIL_W-1:0] FAIL_TO           = 3'd5;

  // visit order
  localparam logic [CLS_W-1:0] CLS_BOUNCE_TO    = 3'd0;
  localparam logic [CLS_W-1:0] CLS_BOUNCE_TO_IP = 3'd1;
  localparam logic [CLS_W-1:0] CLS_TO_IP_FROM   = 3'd2;
  localparam logic [CLS_W-1:0] CLS_TO_IP        = 3'd3;
  localparam logic [CLS_W-1:0] CLS_TO           = 3'd4;

  typedef struct packed {
    logic [TIME_W-1:0] now_time;
    logic              record_msg;
    logic              from_bounce;
    logic              whitelisted;
    logic [IDX_W-1:0]  idx_to;
    logic [IDX_W-1:0]  idx_to_ip;
    logic [IDX_W-1:0]  idx_to_ip_from;
    logic [IDX_W-1:0]  idx_bounce_to;
    logic [IDX_W-1:0]  idx_bounce_to_ip;
  } in_word_t;

  typedef struct packed {
    logic              allowed;
    logic [FAIL_W-1:0] failed_class;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEL,
    ST_QUOT,
    ST_ADDR,
    ST_READ,
    ST_DIFF,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DRAIN,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load_item;
    logic next_class;
    logic calc_quot;
    logic calc_addr;
    logic calc_diff;
    logic mul_lo;
    logic mul_hi;
    logic calc_drain;
    logic write;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic white;
    logic cls_en;
    logic cls_last;
    logic fail_now;
    logic out_free;
  } stat_t;

  function automatic logic [CFG_IDX_W-1:0] class_reg(input logic [CLS_W-1:0] cls);
    logic [CFG_IDX_W-1:0] r;
    unique case (cls)
      CLS_BOUNCE_TO:    r = REG_BOUNCE_TO;
      CLS_BOUNCE_TO_IP: r = REG_BOUNCE_TO_IP;
      CLS_TO_IP_FROM:   r = REG_TO_IP_FROM;
      CLS_TO_IP:        r = REG_TO_IP;
      default:          r = REG_TO;
    endcase
    return r;
  endfunction

  function automatic logic [FAIL_W-1:0] fail_code(input logic [CLS_W-1:0] cls);
    logic [FAIL_W-1:0] r;
    unique case (cls)
      CLS_BOUNCE_TO:    r = FAIL_BOUNCE_TO;
      CLS_BOUNCE_TO_IP: r = FAIL_BOUNCE_TO_IP;
      CLS_TO_IP_FROM:   r = FAIL_TO_IP_FROM;
      CLS_TO_IP:        r = FAIL_TO_IP;
      default:          r = FAIL_TO;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/multi_class_leaky_bucket_policer_core.sv -----
// Multi-class leaky-bucket policer: top level joining controller and datapath.
//
// Request words enter on in_valid/in_ready, one verdict word leaves on
// out_valid/out_ready per request; limits are written on cfg_valid/cfg_ready
// (index 0..4, higher indexes ignored), and the user must write them only while
// the block is idle; the block itself does not enforce this. One request is
// worked at a time. The verdict follows the class steps and, for each bucket
// visited, the steps of index reduction, store read, elapsed time, two 24x24
// partial products, drain and read-modify-write.
// The verdict sits in an output register; a new request is taken while it
// waits, and the next verdict is held back until the receiver takes it.
// After reset the bucket store is cleared one entry per cycle, all BUCKETS
// entries, during which no request is taken; limit writes are still taken.
`default_nettype none
module multi_class_leaky_bucket_policer_core #(
  parameter int BUCKETS = mclbp_pkg::BUCKETS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire mclbp_pkg::in_word_t             in_data,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      mclbp_pkg::out_word_t            out_data,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [mclbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mclbp_pkg::LIMIT_W-1:0]   cfg_data
);

  mclbp_pkg::cmd_t  cmd;
  mclbp_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  mclbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mclbp_dp #(
    .BUCKETS (BUCKETS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/mclbp_ram.sv -----
// Generic single-port-write, registered-read RAM.
`default_nettype none
module mclbp_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mclbp_ctrl.sv -----
// Controller state machine: sequences clearing, class visits and result handoff.
`default_nettype none
`include "assert_macros.svh"
module mclbp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire mclbp_pkg::stat_t  stat,
  output      mclbp_pkg::cmd_t   cmd
);

  mclbp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mclbp_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mclbp_pkg::ST_CLEAR:  if (stat.clear_done) state_next = mclbp_pkg::ST_IDLE;
      mclbp_pkg::ST_IDLE:   if (in_valid) state_next = mclbp_pkg::ST_SEL;
      mclbp_pkg::ST_SEL: begin
        if (stat.white) begin
          state_next = mclbp_pkg::ST_DONE;
        end else if (stat.cls_en) begin
          state_next = mclbp_pkg::ST_QUOT;
        end else if (stat.cls_last) begin
          state_next = mclbp_pkg::ST_DONE;
        end
      end
      mclbp_pkg::ST_QUOT:   state_next = mclbp_pkg::ST_ADDR;
      mclbp_pkg::ST_ADDR:   state_next = mclbp_pkg::ST_READ;
      mclbp_pkg::ST_READ:   state_next = mclbp_pkg::ST_DIFF;
      mclbp_pkg::ST_DIFF:   state_next = mclbp_pkg::ST_MUL_LO;
      mclbp_pkg::ST_MUL_LO: state_next = mclbp_pkg::ST_MUL_HI;
      mclbp_pkg::ST_MUL_HI: state_next = mclbp_pkg::ST_DRAIN;
      mclbp_pkg::ST_DRAIN:  state_next = mclbp_pkg::ST_WRITE;
      mclbp_pkg::ST_WRITE: begin
        if (stat.fail_now || stat.cls_last) begin
          state_next = mclbp_pkg::ST_DONE;
        end else begin
          state_next = mclbp_pkg::ST_SEL;
        end
      end
      mclbp_pkg::ST_DONE:   if (stat.out_free) state_next = mclbp_pkg::ST_IDLE;
      default:              state_next = mclbp_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      mclbp_pkg::ST_CLEAR:  cmd.clear_step = 1'b1;
      mclbp_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      mclbp_pkg::ST_SEL:
        cmd.next_class = !stat.white && !stat.cls_en && !stat.cls_last;
      mclbp_pkg::ST_QUOT:   cmd.calc_quot = 1'b1;
      mclbp_pkg::ST_ADDR:   cmd.calc_addr = 1'b1;
      mclbp_pkg::ST_READ:   ;
      mclbp_pkg::ST_DIFF:   cmd.calc_diff = 1'b1;
      mclbp_pkg::ST_MUL_LO: cmd.mul_lo = 1'b1;
      mclbp_pkg::ST_MUL_HI: cmd.mul_hi = 1'b1;
      mclbp_pkg::ST_DRAIN:  cmd.calc_drain = 1'b1;
      mclbp_pkg::ST_WRITE: begin
        cmd.write      = 1'b1;
        cmd.next_class = !stat.fail_now && !stat.cls_last;
      end
      mclbp_pkg::ST_DONE:   cmd.load_result = stat.out_free;
      default:              ;
    endcase
  end

  `MCLBP_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "accepted while busy")
  `MCLBP_NEVER(a_clear_vs_write, cmd.clear_step && cmd.write, "clear collides with bucket write")

endmodule
`default_nettype wire

// ----- hw/rtl/mclbp_dp.sv -----
// Datapath: limit registers, bucket store, drain arithmetic and result register.
`default_nettype none
`include "assert_macros.svh"
module mclbp_dp #(
  parameter int BUCKETS = mclbp_pkg::BUCKETS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire mclbp_pkg::in_word_t                 in_data,
  input  wire logic                                cfg_valid,
  input  wire logic [mclbp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mclbp_pkg::LIMIT_W-1:0]       cfg_data,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      mclbp_pkg::out_word_t                out_data,
  input  wire mclbp_pkg::cmd_t                     cmd,
  output      mclbp_pkg::stat_t                    stat
);

  localparam int AW     = $clog2(BUCKETS);
  localparam int PW     = mclbp_pkg::IDX_W + 18;
  localparam int RECIP  = (1 << mclbp_pkg::RECIP_SHIFT) / BUCKETS;
  localparam int WORD_W = mclbp_pkg::TIME_W + mclbp_pkg::LEVEL_W;
  localparam int TW     = mclbp_pkg::TIME_W;
  localparam int LW     = mclbp_pkg::LEVEL_W;
  localparam int RW     = mclbp_pkg::RATE_W;
  localparam int PRW    = TW;
  localparam int DW     = 34;
  localparam int SW     = 36;

  localparam logic [PW-1:0] RECIP_W   = PW'(RECIP);
  localparam logic [PW-1:0] BUCKETS_W = PW'(BUCKETS);
  localparam logic [DW-1:0] DRAIN_SAT = DW'(1) << 33;
  localparam logic [SW-1:0] ONE_MSG   = SW'(65536);
  localparam logic [SW-1:0] LEVEL_MAX = SW'(64'hFFFF_FFFF);

  mclbp_pkg::in_word_t              item;
  logic [mclbp_pkg::LIMIT_W-1:0]    lim [mclbp_pkg::NUM_CLASSES];
  logic [mclbp_pkg::CLS_W-1:0]      cls;
  logic                             fail;
  logic [mclbp_pkg::IDX_W-1:0]      quot;
  logic [AW-1:0]                    addr;
  logic [AW-1:0]                    clr_cnt;
  logic [TW-1:0]                    mag;
  logic                             back;
  logic [LW-1:0]                    level;
  logic [PRW-1:0]                   prod_lo;
  logic [PRW-1:0]                   prod_hi;
  logic [DW-1:0]                    drain;
  mclbp_pkg::out_word_t             out_r;

  logic [mclbp_pkg::IDX_W-1:0]      sel_idx;
  logic [mclbp_pkg::LIMIT_W-1:0]    sel_lim;
  logic [RW-1:0]                    rate;
  logic [mclbp_pkg::BURST_W-1:0]    burst;
  logic [PW-1:0]                    quot_prod;
  logic [PW-1:0]                    rem;
  logic [PW-1:0]                    rem_fix;
  logic [WORD_W-1:0]                rdata;
  logic [WORD_W-1:0]                wdata;
  logic [AW-1:0]                    waddr;
  logic [TW-1:0]                    stamp;
  logic [LW-1:0]                    rd_level;
  logic [TW:0]                      prod_sum;
  logic [SW-1:0]                    lvl_sum;
  logic [LW-1:0]                    lvl_new;
  logic                             over;

  always_comb begin
    unique case (cls)
      mclbp_pkg::CLS_BOUNCE_TO:    sel_idx = item.idx_bounce_to;
      mclbp_pkg::CLS_BOUNCE_TO_IP: sel_idx = item.idx_bounce_to_ip;
      mclbp_pkg::CLS_TO_IP_FROM:   sel_idx = item.idx_to_ip_from;
      mclbp_pkg::CLS_TO_IP:        sel_idx = item.idx_to_ip;
      default:                     sel_idx = item.idx_to;
    endcase
  end

  assign sel_lim = lim[mclbp_pkg::class_reg(cls)];
  assign rate    = sel_lim[RW-1:0];
  assign burst   = sel_lim[mclbp_pkg::LIMIT_W-1:RW];

  // index modulo BUCKETS: reciprocal estimate, then one correction
  assign quot_prod = PW'(sel_idx) * RECIP_W;
  assign rem       = PW'(sel_idx) - PW'(quot) * BUCKETS_W;
  assign rem_fix   = (rem >= BUCKETS_W) ? rem - BUCKETS_W : rem;

  assign stamp    = rdata[WORD_W-1:LW];
  assign rd_level = rdata[LW-1:0];
  assign prod_sum = {1'b0, prod_hi[RW-1:0], {RW{1'b0}}} + {1'b0, prod_lo};

  always_comb begin
    lvl_sum = back ? SW'(level) + SW'(drain) : SW'(level) - SW'(drain);
    if (item.record_msg) begin
      lvl_sum = lvl_sum + ONE_MSG;
    end
    if (lvl_sum[SW-1]) begin
      lvl_new = '0;
    end else if (lvl_sum > LEVEL_MAX) begin
      lvl_new = '1;
    end else begin
      lvl_new = lvl_sum[LW-1:0];
    end
    over = !item.record_msg && (lvl_new > {burst, 16'h0000});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mclbp_pkg::NUM_CLASSES; i++) begin
        lim[i] <= '0;
      end
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      cls       <= '0;
      fail      <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_index < mclbp_pkg::CFG_IDX_W'(mclbp_pkg::NUM_CLASSES))) begin
        lim[cfg_index] <= cfg_data;
      end
      if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.load_item) begin
        cls  <= '0;
        fail <= 1'b0;
      end else if (cmd.next_class) begin
        cls <= cls + mclbp_pkg::CLS_W'(1);
      end
      if (cmd.write) begin
        fail <= over;
      end
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
    if (cmd.calc_quot) begin
      quot <= quot_prod[mclbp_pkg::RECIP_SHIFT +: mclbp_pkg::IDX_W];
    end
    if (cmd.calc_addr) begin
      addr <= rem_fix[AW-1:0];
    end
    if (cmd.calc_diff) begin
      back  <= item.now_time < stamp;
      mag   <= (item.now_time < stamp) ? stamp - item.now_time : item.now_time - stamp;
      level <= rd_level;
    end
    if (cmd.mul_lo) begin
      prod_lo <= PRW'(mag[RW-1:0]) * PRW'(rate);
    end
    if (cmd.mul_hi) begin
      prod_hi <= PRW'(mag[TW-1:RW]) * PRW'(rate);
    end
    if (cmd.calc_drain) begin
      if (level == '0) begin
        drain <= '0;
      end else if (prod_hi[PRW-1:RW] != '0) begin
        drain <= DRAIN_SAT;
      end else begin
        drain <= DW'(prod_sum[TW:16]);
      end
    end
    if (cmd.load_result) begin
      out_r.allowed      <= !fail;
      out_r.failed_class <= fail ? mclbp_pkg::fail_code(cls) : mclbp_pkg::FAIL_NONE;
    end
  end

  assign waddr = cmd.clear_step ? clr_cnt : addr;
  assign wdata = cmd.clear_step ? '0 : {item.now_time, lvl_new};

  mclbp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BUCKETS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.clear_step || cmd.write),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  assign out_data = out_r;

  always_comb begin
    stat.clear_done = clr_cnt == AW'(BUCKETS - 1);
    stat.white      = item.whitelisted;
    stat.cls_en     = (item.from_bounce || cls > mclbp_pkg::CLS_BOUNCE_TO_IP) &&
                      rate != '0 && burst != '0;
    stat.cls_last   = cls == mclbp_pkg::CLS_TO;
    stat.fail_now   = over;
    stat.out_free   = !out_valid || out_ready;
  end

  `MCLBP_ASSERT(a_result_slot_free, cmd.load_result |-> (!out_valid || out_ready), "result overrun")
  `MCLBP_ASSERT(a_result_code, out_valid |-> (out_data.allowed == (out_data.failed_class == mclbp_pkg::FAIL_NONE)), "result code mismatch")
  `MCLBP_NEVER(a_update_fail, cmd.write && over && item.record_msg, "update request failed")

endmodule
`default_nettype wire

// ----- verif/multi_class_leaky_bucket_policer_core_tb.sv -----
// Self-checking testbench for the multi-class leaky-bucket policer core.
`timescale 1ns / 1ps
module multi_class_leaky_bucket_policer_core_tb;
  import mclbp_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int BUCKETS = BUCKETS_DEF;
  localparam int CYCLE_LIMIT = 800000;
  localparam int TAIL_CYCLES = 64;
  localparam int GAP_MAX = 60;
  localparam int RX_EPOCH = 200;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int HOT_SLOTS = 8;
  localparam int BURST_MAX = 'hFFFF;
  localparam int RATE_MAX = 'hFFFFFF;
  localparam int RATE_ONE = 'h10000;
  localparam longint ONE_MSG = 64'h1_0000;
  localparam longint DRAIN_CAP = 64'h2_0000_0000;
  localparam longint LEVEL_MAX = 64'hFFFF_FFFF;
  localparam logic [TIME_W-1:0] SEC = 48'h1_0000;
  localparam logic [TIME_W-1:0] TIME_TOP = 48'hFFFF_FFFF_FFFF;
  localparam logic [IDX_W-1:0] IDX_TOP = 10'h3FF;

  typedef enum {RX_OPEN, RX_COIN, RX_CHOKE} rx_mode_t;
  typedef enum {LIM_TIGHT, LIM_LOOSE, LIM_SPARSE, LIM_EXTREME, LIM_WILD} limit_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0] cfg_data = '0;

  bit [LIMIT_W-1:0] limit_word [NUM_CLASSES];
  bit [LEVEL_W-1:0] level_mem [BUCKETS];
  bit [TIME_W-1:0] stamp_mem [BUCKETS];
  out_word_t verdict_q [$];

  logic [IDX_W-1:0] hot_idx [HOT_SLOTS];
  logic [TIME_W-1:0] clock_now = '0;
  int burst_left = 0;
  int err_count = 0;
  int cycle_count = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int rx_tick = 0;
  int rx_hold = 0;

  multi_class_leaky_bucket_policer_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- bucket arithmetic ----------------

  function automatic longint drain_amount(input logic [TIME_W-1:0] span,
                                          input logic [RATE_W-1:0] rate);
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] prod;
    hi = {40'b0, span[TIME_W-1:RATE_W]} * {40'b0, rate};
    lo = {40'b0, span[RATE_W-1:0]} * {40'b0, rate};
    if (hi >= 64'h100_0000) return DRAIN_CAP;
    prod = ((hi << RATE_W) + lo) >> 16;
    if (prod > DRAIN_CAP) return DRAIN_CAP;
    return prod;
  endfunction

  // returns 0 when a check-only word overflows the bucket
  function automatic bit visit_class(input logic [LIMIT_W-1:0] lim, input logic [IDX_W-1:0] idx,
                                     input logic [TIME_W-1:0] now, input logic upd);
    logic [RATE_W-1:0] rate;
    logic [BURST_W-1:0] burst;
    int slot;
    longint lvl;
    rate = lim[RATE_W-1:0];
    burst = lim[LIMIT_W-1:RATE_W];
    if (rate == 0 || burst == 0) return 1'b1;
    slot = idx % BUCKETS;
    lvl = {32'b0, level_mem[slot]};
    if (lvl > 0) begin
      if (now < stamp_mem[slot]) lvl += drain_amount(stamp_mem[slot] - now, rate);
      else lvl -= drain_amount(now - stamp_mem[slot], rate);
    end
    if (upd) lvl += ONE_MSG;
    if (lvl < 0) lvl = 0;
    if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
    level_mem[slot] = lvl[LEVEL_W-1:0];
    stamp_mem[slot] = now;
    return upd || (lvl <= {32'b0, burst, 16'b0});
  endfunction

  function automatic void predict_verdict(input in_word_t w);
    out_word_t v;
    logic [FAIL_W-1:0] code;
    code = FAIL_NONE;
    if (!w.whitelisted) begin
      if (w.from_bounce && !visit_class(limit_word[REG_BOUNCE_TO], w.idx_bounce_to,
                                        w.now_time, w.record_msg))
        code = FAIL_BOUNCE_TO;
      else if (w.from_bounce && !visit_class(limit_word[REG_BOUNCE_TO_IP], w.idx_bounce_to_ip,
                                             w.now_time, w.record_msg))
        code = FAIL_BOUNCE_TO_IP;
      else if (!visit_class(limit_word[REG_TO_IP_FROM], w.idx_to_ip_from,
                            w.now_time, w.record_msg))
        code = FAIL_TO_IP_FROM;
      else if (!visit_class(limit_word[REG_TO_IP], w.idx_to_ip, w.now_time, w.record_msg))
        code = FAIL_TO_IP;
      else if (!visit_class(limit_word[REG_TO], w.idx_to, w.now_time, w.record_msg))
        code = FAIL_TO;
    end
    v.allowed = (code == FAIL_NONE);
    v.failed_class = code;
    verdict_q.push_back(v);
  endfunction

  // ---------------- verdict checking ----------------

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $error("verdict word with no request pending: allowed %0d failed_class %0d",
               out_data.allowed, out_data.failed_class);
        err_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_data.allowed !== want.allowed) begin
          $error("allowed: expected %0d, got %0d", want.allowed, out_data.allowed);
          err_count++;
        end
        if (out_data.failed_class !== want.failed_class) begin
          $error("failed_class: expected %0d, got %0d", want.failed_class,
                 out_data.failed_class);
          err_count++;
        end
      end
    end
  end

  // receiver back-pressure, mode redrawn at random every epoch
  always @(negedge clk) begin
    if (rx_tick == 0) rx_mode = rx_mode_t'($urandom_range(2));
    rx_tick = (rx_tick + 1) % RX_EPOCH;
    case (rx_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= $urandom_range(1);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
        end else begin
          out_ready <= ~out_ready;
          rx_hold = out_ready ? $urandom_range(40, 1) : $urandom_range(3);
        end
      end
    endcase
  end

  // ---------------- drivers ----------------

  task automatic send_request(input in_word_t w);
    @(negedge clk);
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_verdict(w);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(GAP_MAX)) @(negedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 10) : $urandom_range(4);
    end
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] ix, input logic [LIMIT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (ix < NUM_CLASSES) limit_word[ix] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle_all();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // ---------------- stimulus helpers ----------------

  function automatic logic [LIMIT_W-1:0] limit_of(input int burst, input int rate);
    return {burst[BURST_W-1:0], rate[RATE_W-1:0]};
  endfunction

  function automatic in_word_t make_request(input logic [TIME_W-1:0] t,
                                            input logic upd, bounce, white,
                                            input logic [IDX_W-1:0] i_to, i_to_ip, i_ip_from,
                                            input logic [IDX_W-1:0] i_bto, i_bto_ip);
    in_word_t r;
    r.now_time = t;
    r.record_msg = upd;
    r.from_bounce = bounce;
    r.whitelisted = white;
    r.idx_to = i_to;
    r.idx_to_ip = i_to_ip;
    r.idx_to_ip_from = i_ip_from;
    r.idx_bounce_to = i_bto;
    r.idx_bounce_to_ip = i_bto_ip;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(9) == 0) return $urandom_range(BUCKETS - 1);
    return hot_idx[$urandom_range(HOT_SLOTS - 1)];
  endfunction

  function automatic logic [TIME_W-1:0] next_stamp(input int step_max);
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) clock_now += $urandom_range(step_max);
    else if (roll < 88) clock_now -= $urandom_range(step_max);
    else if (roll < 96) clock_now += $urandom;
    else clock_now = {$urandom, $urandom};
    return clock_now;
  endfunction

  function automatic in_word_t random_request(input int step_max, input int upd_pct);
    in_word_t r;
    logic [IDX_W-1:0] shared;
    r.now_time = next_stamp(step_max);
    r.record_msg = ($urandom_range(99) < upd_pct);
    r.from_bounce = $urandom_range(1);
    r.whitelisted = ($urandom_range(19) == 0);
    r.idx_to = pick_index();
    r.idx_to_ip = pick_index();
    r.idx_to_ip_from = pick_index();
    r.idx_bounce_to = pick_index();
    r.idx_bounce_to_ip = pick_index();
    if ($urandom_range(9) == 0) begin
      shared = pick_index();
      r.idx_to = shared;
      r.idx_to_ip = shared;
      r.idx_to_ip_from = shared;
      r.idx_bounce_to = shared;
      r.idx_bounce_to_ip = shared;
    end
    return r;
  endfunction

  function automatic logic [LIMIT_W-1:0] limit_for(input limit_style_t style);
    case (style)
      LIM_TIGHT: return limit_of($urandom_range(3, 1), $urandom_range('h20000, 'h800));
      LIM_LOOSE: return limit_of($urandom_range(24, 4), $urandom_range('h40000, 'h100));
      LIM_SPARSE: begin
        case ($urandom_range(3))
          0: return limit_of(0, $urandom_range(RATE_MAX));
          1: return limit_of($urandom_range(BURST_MAX), 0);
          default: return limit_of($urandom_range(3, 1), $urandom_range('h20000, 'h800));
        endcase
      end
      LIM_EXTREME: begin
        case ($urandom_range(3))
          0: return limit_of(BURST_MAX, RATE_MAX);
          1: return limit_of(1, 1);
          2: return limit_of(1, RATE_MAX);
          default: return limit_of(BURST_MAX, 1);
        endcase
      end
      default: return limit_of($urandom, $urandom);
    endcase
  endfunction

  task automatic load_limits(input limit_style_t style);
    logic [CFG_IDX_W-1:0] spare;
    for (int c = 0; c < NUM_CLASSES; c++) write_limit(c[CFG_IDX_W-1:0], limit_for(style));
    if (style == LIM_WILD) begin
      spare = $urandom_range((1 << CFG_IDX_W) - 1, NUM_CLASSES);
      write_limit(spare, limit_of($urandom, $urandom));
    end
  endtask

  // ---------------- tests ----------------

  // reset limits skip every class; writes past the last register change nothing
  task automatic test_open_limits();
    send_request(make_request('0, 1'b1, 1'b1, 1'b0, 0, 1, 2, 3, 4));
    send_request(make_request(SEC, 1'b0, 1'b1, 1'b0, 0, 1, 2, 3, 4));
    settle_all();
    for (int ix = NUM_CLASSES; ix < (1 << CFG_IDX_W); ix++)
      write_limit(ix[CFG_IDX_W-1:0], {LIMIT_W{1'b1}});
    send_request(make_request(SEC, 1'b1, 1'b0, 1'b0, 0, 1, 2, 3, 4));
    send_request(make_request(SEC, 1'b0, 1'b1, 1'b0, 0, 1, 2, 3, 4));
  endtask

  task automatic test_burst_edges();
    settle_all();
    write_limit(REG_BOUNCE_TO, limit_of(1, RATE_ONE));
    write_limit(REG_BOUNCE_TO_IP, limit_of(2, RATE_ONE));
    write_limit(REG_TO_IP_FROM, limit_of(1, 'h8000));
    write_limit(REG_TO_IP, limit_of(2, 'h4000));
    write_limit(REG_TO, limit_of(3, 'h2000));
    send_request(make_request('0, 1'b1, 1'b1, 1'b1, 1, 2, 3, 6, 7));
    send_request(make_request(SEC, 1'b1, 1'b0, 1'b0, 1, 2, 3, 6, 7));
    send_request(make_request(SEC, 1'b1, 1'b0, 1'b0, 1, 2, 3, 6, 7));
    send_request(make_request(SEC, 1'b0, 1'b0, 1'b0, 1, 2, 3, 6, 7));
    send_request(make_request(SEC, 1'b0, 1'b1, 1'b0, 1, 2, 3, 6, 7));
    send_request(make_request(3 * SEC, 1'b0, 1'b0, 1'b0, 1, 2, 3, 6, 7));
    // one bucket shared by every class
    repeat (2) send_request(make_request(3 * SEC, 1'b1, 1'b1, 1'b0, 9, 9, 9, 9, 9));
    send_request(make_request(3 * SEC, 1'b0, 1'b1, 1'b0, 9, 9, 9, 9, 9));
    // clock runs backward
    send_request(make_request(SEC / 2, 1'b0, 1'b0, 1'b0, 1, 2, 3, 6, 7));
    send_request(make_request(TIME_TOP, 1'b0, 1'b1, 1'b0, 1, 2, 3, 6, 7));
    send_request(make_request(TIME_TOP, 1'b1, 1'b1, 1'b0, IDX_TOP, IDX_TOP, IDX_TOP, 0, 0));
    send_request(make_request(TIME_TOP, 1'b0, 1'b1, 1'b0, IDX_TOP, IDX_TOP, IDX_TOP, 0, 0));
  endtask

  task automatic test_extreme_limits();
    settle_all();
    write_limit(REG_BOUNCE_TO, limit_of(BURST_MAX, RATE_MAX));
    write_limit(REG_BOUNCE_TO_IP, limit_of(1, 1));
    write_limit(REG_TO_IP_FROM, limit_of(BURST_MAX, 0));
    write_limit(REG_TO_IP, limit_of(0, RATE_MAX));
    write_limit(REG_TO, limit_of(1, RATE_MAX));
    send_request(make_request(48'h8000_0000_0000, 1'b1, 1'b1, 1'b0, 20, 21, 22, 10, 11));
    send_request(make_request('0, 1'b0, 1'b1, 1'b0, 20, 21, 22, 10, 11));
    send_request(make_request('0, 1'b1, 1'b1, 1'b0, 20, 21, 22, 10, 11));
    send_request(make_request(1, 1'b0, 1'b1, 1'b0, 20, 21, 22, 30, 11));
    send_request(make_request(2, 1'b0, 1'b1, 1'b0, 20, 21, 22, 30, 11));
    send_request(make_request(TIME_TOP, 1'b0, 1'b1, 1'b0, 20, 21, 22, 10, 11));
    send_request(make_request(TIME_TOP, 1'b1, 1'b0, 1'b1, 20, 21, 22, 10, 11));
  endtask

  task automatic test_random_traffic();
    limit_style_t plan [7];
    int step_max;
    int upd_pct;
    plan = '{LIM_TIGHT, LIM_SPARSE, LIM_LOOSE, LIM_EXTREME, LIM_TIGHT, LIM_WILD, LIM_SPARSE};
    foreach (plan[p]) begin
      settle_all();
      load_limits(plan[p]);
      foreach (hot_idx[h]) hot_idx[h] = $urandom_range(BUCKETS - 1);
      case (plan[p])
        LIM_LOOSE: step_max = 'h800;
        LIM_EXTREME: step_max = 'h40;
        LIM_WILD: step_max = 'h10000;
        default: step_max = 'h3000;
      endcase
      upd_pct = $urandom_range(80, 50);
      repeat (RANDOM_PER_PHASE) send_request(random_request(step_max, upd_pct));
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_open_limits();
    test_burst_edges();
    test_extreme_limits();
    test_random_traffic();
    settle_all();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/mclbp_pkg.sv
hw/rtl/mclbp_ram.sv
hw/rtl/mclbp_ctrl.sv
hw/rtl/mclbp_dp.sv
hw/rtl/multi_class_leaky_bucket_policer_core.sv
verif/multi_class_leaky_bucket_policer_core_tb.sv
